@@ rtl/lru_page_buffer_directory_defines.svh @@
// assertion macros for the page buffer directory
`ifndef LRU_PAGE_BUFFER_DIRECTORY_DEFINES_SVH
`define LRU_PAGE_BUFFER_DIRECTORY_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define LPBD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define LPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpbd_pkg.sv @@
package lpbd_pkg;
    localparam int NumFramesDefault = 16;
    localparam int MaxResults       = 16;
    localparam int QueueDepth       = 2;

    localparam logic [1:0] OpRead     = 2'd0;
    localparam logic [1:0] OpWrite    = 2'd1;
    localparam logic [1:0] OpFlushOne = 2'd2;
    localparam logic [1:0] OpFlushAll = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  table_req;
        logic [19:0] page;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  frame;
        logic        hit;
        logic        fetch_needed;
        logic        writeback_valid;
        logic [3:0]  writeback_table;
        logic [19:0] writeback_page;
        logic        last;
    } t_res;
endpackage

@@ rtl/lpbd_fifo.sv @@
module lpbd_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [Width-1:0] o_data
);
    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
    logic [Width-1:0] r_mem [Depth];
    logic [Aw-1:0]    r_wp, r_rp;
    logic [Aw:0]      r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (Aw+1)'(Depth));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Aw+1)'(w_do_push) - (Aw+1)'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

@@ rtl/lpbd_engine.sv @@
`include "lru_page_buffer_directory_defines.svh"
module lpbd_engine #(
    parameter int NumFrames = lpbd_pkg::NumFramesDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lpbd_pkg::t_cmd    i_cmd,
    output logic              o_cmd_take,
    output logic              o_res_valid,
    output lpbd_pkg::t_res    o_res,
    input  logic              i_res_take
);
    localparam int Fw = (NumFrames > 1) ? $clog2(NumFrames) : 1;
    localparam int Cw = $clog2(lpbd_pkg::MaxResults + 1);
    localparam logic [2:0] StIdle = 3'd0, StLook = 3'd1, StFlush = 3'd2, StOut = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [NumFrames-1:0] r_valid, r_dirty;
    logic [3:0]  r_ttag [NumFrames];
    logic [19:0] r_ptag [NumFrames];
    logic [Fw-1:0] r_rank [NumFrames];
    lpbd_pkg::t_cmd r_cmd;
    lpbd_pkg::t_res r_res;
    logic [Fw-1:0] r_idx;
    logic [Cw-1:0] r_cnt;

    function automatic logic r_cmd_is_flush(input logic [1:0] op);
        r_cmd_is_flush = (op == lpbd_pkg::OpFlushOne) || (op == lpbd_pkg::OpFlushAll);
    endfunction

    // frames above idx that might still be selected (table checked per frame)
    function automatic logic [NumFrames-1:0] f_later(input logic [Fw-1:0] idx);
        logic [NumFrames-1:0] m;
        for (int i = 0; i < NumFrames; i++) begin
            m[i] = (Fw'(i) > idx) &&
                   (r_cmd.op == lpbd_pkg::OpFlushAll || r_ttag[i] == r_cmd.table_req);
        end
        f_later = m;
    endfunction

    // lookup
    logic [NumFrames-1:0] w_match;
    logic          w_hit;
    logic [Fw-1:0] w_hidx, w_vidx, w_f;
    always_comb begin
        w_hit  = 1'b0;
        w_hidx = '0;
        w_vidx = '0;
        for (int i = NumFrames-1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && r_ttag[i] == r_cmd.table_req &&
                         r_ptag[i] == r_cmd.page;
            if (w_match[i]) begin
                w_hit  = 1'b1;
                w_hidx = Fw'(i);
            end
            if (r_rank[i] == Fw'(NumFrames-1)) begin
                w_vidx = Fw'(i);
            end
        end
        w_f = w_hit ? w_hidx : w_vidx;
    end

    logic w_sel, w_last_idx, w_flush_emit;
    assign w_sel = r_valid[r_idx] && r_dirty[r_idx] &&
                   (r_cmd.op == lpbd_pkg::OpFlushAll || r_ttag[r_idx] == r_cmd.table_req);
    assign w_last_idx = (r_idx == Fw'(NumFrames-1));

    assign o_cmd_take  = (r_state == StIdle) && i_cmd_valid;
    assign o_res_valid = (r_state == StOut);
    assign o_res       = r_res;
    assign w_flush_emit = (r_state == StFlush) && (w_sel || w_last_idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle:  if (i_cmd_valid) begin
                n_state = r_cmd_is_flush(i_cmd.op) ? StFlush : StLook;
            end
            StLook:  n_state = StOut;
            StFlush: if (w_sel || w_last_idx) begin
                n_state = StOut;
            end
            StOut:   if (i_res_take) begin
                n_state = r_res.last ? StIdle : StFlush;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_valid <= '0;
            r_dirty <= '0;
            for (int i = 0; i < NumFrames; i++) begin
                r_rank[i] <= Fw'(i);
            end
        end else begin
            r_state <= n_state;
            if (r_state == StLook) begin
                for (int i = 0; i < NumFrames; i++) begin
                    if (r_rank[i] < r_rank[w_f]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
                r_rank[w_f]  <= '0;
                r_valid[w_f] <= 1'b1;
                r_dirty[w_f] <= (r_cmd.op == lpbd_pkg::OpWrite) ||
                                (w_hit && r_dirty[w_f]);
            end
            if ((r_state == StFlush) && w_sel) begin
                r_dirty[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd   <= i_cmd;
            r_idx   <= '0;
            r_cnt   <= '0;
        end
        if (r_state == StLook) begin
            r_res.frame           <= 4'(w_f);
            r_res.hit             <= w_hit;
            r_res.fetch_needed    <= !w_hit && r_cmd.op == lpbd_pkg::OpRead;
            r_res.writeback_valid <= !w_hit && r_valid[w_f] && r_dirty[w_f];
            r_res.writeback_table <= (!w_hit && r_valid[w_f] && r_dirty[w_f])
                                     ? r_ttag[w_f] : 4'd0;
            r_res.writeback_page  <= (!w_hit && r_valid[w_f] && r_dirty[w_f])
                                     ? r_ptag[w_f] : 20'd0;
            r_res.last            <= 1'b1;
            if (!w_hit) begin
                r_ttag[w_f] <= r_cmd.table_req;
                r_ptag[w_f] <= r_cmd.page;
            end
        end
        if (w_flush_emit) begin
            // walk on; emit either a write-back or the closing empty result
            if (!w_last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_sel) begin
                r_cnt <= r_cnt + 1'b1;
                r_res.frame           <= 4'(r_idx);
                r_res.writeback_valid <= 1'b1;
                r_res.writeback_table <= r_ttag[r_idx];
                r_res.writeback_page  <= r_ptag[r_idx];
            end else begin
                r_res.frame           <= '0;
                r_res.writeback_valid <= 1'b0;
                r_res.writeback_table <= '0;
                r_res.writeback_page  <= '0;
            end
            r_res.hit          <= 1'b0;
            r_res.fetch_needed <= 1'b0;
            r_res.last         <= w_last_idx || !w_sel ||
                                  (r_cnt == Cw'(lpbd_pkg::MaxResults - 1)) ||
                                  !(|(r_valid & r_dirty & f_later(r_idx)));
        end else if (r_state == StFlush) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    `LPBD_ASSERT_ALWAYS(a_take_idle, i_clk, i_rst_n,
        !o_cmd_take || !o_res_valid, "command taken while a result is held")
    `LPBD_ASSERT_NEXT(a_look_out, i_clk, i_rst_n, r_state == StLook,
        r_state == StOut && r_res.last, "access did not give one final result")
    `LPBD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res_valid && !i_res_take,
        o_res_valid && $stable(r_res), "pending result changed")
endmodule

@@ rtl/lru_page_buffer_directory.sv @@
// LRU page buffer directory: a fully associative table of page frames keyed by
// (table, page). An access hits or takes the least recently used frame, giving
// one result with a write-back when the victim is dirty. A flush walks the
// frames one per cycle while no result is waiting to be popped and gives one
// result per dirty frame of the selected table, or of every table for a flush
// all (up to sixteen), or one empty result. Commands enter a two-entry queue,
// so pushes are taken while the engine works. An access passes through the
// engine's take, lookup (parallel tag compare) and result states. Results wait
// in the output register until popped.
module lru_page_buffer_directory #(
    parameter int NUM_FRAMES = lpbd_pkg::NumFramesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_table_req,
    input  logic [19:0] i_page,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_frame,
    output logic        o_hit,
    output logic        o_fetch_needed,
    output logic        o_writeback_valid,
    output logic [3:0]  o_writeback_table,
    output logic [19:0] o_writeback_page,
    output logic        o_last
);
    lpbd_pkg::t_cmd w_cmd_in, w_cmd_q;
    lpbd_pkg::t_res w_res;
    logic           w_q_empty, w_take, w_res_valid;

    assign w_cmd_in = '{op: i_op, table_req: i_table_req, page: i_page};

    // front: command queue
    lpbd_fifo #(.Width($bits(lpbd_pkg::t_cmd)), .Depth(lpbd_pkg::QueueDepth)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(w_cmd_in), .o_full(full),
        .i_pop(w_take), .o_empty(w_q_empty), .o_data(w_cmd_q)
    );

    // back: lookup, replacement and flush walk
    lpbd_engine #(.NumFrames(NUM_FRAMES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(!w_q_empty), .i_cmd(w_cmd_q), .o_cmd_take(w_take),
        .o_res_valid(w_res_valid), .o_res(w_res), .i_res_take(pop)
    );

    assign empty             = !w_res_valid;
    assign o_frame           = w_res.frame;
    assign o_hit             = w_res.hit;
    assign o_fetch_needed    = w_res.fetch_needed;
    assign o_writeback_valid = w_res.writeback_valid;
    assign o_writeback_table = w_res.writeback_table;
    assign o_writeback_page  = w_res.writeback_page;
    assign o_last            = w_res.last;
endmodule

@@ tb/tb_lru_page_buffer_directory.sv @@
module tb_lru_page_buffer_directory;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAMES = 16;
    // no cycle with a transfer for this long means the block is hung
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_op = lpbd_pkg::OpRead;
    logic [3:0]  i_table_req = '0;
    logic [19:0] i_page = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_frame;
    logic        o_hit;
    logic        o_fetch_needed;
    logic        o_writeback_valid;
    logic [3:0]  o_writeback_table;
    logic [19:0] o_writeback_page;
    logic        o_last;

    lru_page_buffer_directory dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_op(i_op), .i_table_req(i_table_req), .i_page(i_page),
        .empty(empty), .pop(pop),
        .o_frame(o_frame), .o_hit(o_hit), .o_fetch_needed(o_fetch_needed),
        .o_writeback_valid(o_writeback_valid), .o_writeback_table(o_writeback_table),
        .o_writeback_page(o_writeback_page), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // commands waiting to be pushed, and directory results still owed
    lpbd_pkg::t_cmd cmd_q[$];
    lpbd_pkg::t_res owed_q[$];
    int   n_errors = 0;
    bit   calm = 0;       // no idling near the end of the run

    // shadow of the frame directory
    bit          sh_valid[NFRAMES];
    logic [3:0]  sh_table[NFRAMES];
    logic [19:0] sh_page[NFRAMES];
    bit          sh_dirty[NFRAMES];
    int          sh_rank[NFRAMES];

    // pages actually in use, so that hits are common
    logic [19:0] hot_pages[8];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic lpbd_pkg::t_res mk_res(input int f, input bit h, input bit fe,
                                              input bit wv, input logic [3:0] wt,
                                              input logic [19:0] wp, input bit l);
        lpbd_pkg::t_res r;
        r.frame = f[3:0]; r.hit = h; r.fetch_needed = fe; r.writeback_valid = wv;
        r.writeback_table = wt; r.writeback_page = wp; r.last = l;
        return r;
    endfunction

    // work out the results of one accepted command and update the shadow
    task automatic predict_directory(input lpbd_pkg::t_cmd c);
        int f;
        int n;
        int best;
        bit h;
        bit wv;
        logic [3:0] wt;
        logic [19:0] wp;
        f = 0; h = 0; wv = 0; wt = '0; wp = '0; n = 0; best = 0;
        if (c.op == lpbd_pkg::OpRead || c.op == lpbd_pkg::OpWrite) begin
            for (int i = 0; i < NFRAMES; i++)
                if (!h && sh_valid[i] && sh_table[i] == c.table_req && sh_page[i] == c.page) begin
                    f = i; h = 1;
                end
            if (!h) begin
                // victim is the highest rank, first frame on a tie
                for (int i = 0; i < NFRAMES; i++)
                    if (i == 0 || sh_rank[i] > best) begin
                        best = sh_rank[i]; f = i;
                    end
                if (sh_valid[f] && sh_dirty[f]) begin
                    wv = 1; wt = sh_table[f]; wp = sh_page[f];
                end
                sh_valid[f] = 1; sh_table[f] = c.table_req; sh_page[f] = c.page;
                sh_dirty[f] = 0;
            end
            for (int j = 0; j < NFRAMES; j++)
                if (sh_rank[j] < sh_rank[f]) sh_rank[j]++;
            sh_rank[f] = 0;
            if (c.op == lpbd_pkg::OpWrite) sh_dirty[f] = 1;
            owed_q.push_back(mk_res(f, h, !h && c.op == lpbd_pkg::OpRead, wv, wt, wp, 1'b1));
        end else begin
            for (int i = 0; i < NFRAMES && n < lpbd_pkg::MaxResults; i++)
                if (sh_valid[i] && sh_dirty[i] &&
                    (c.op == lpbd_pkg::OpFlushAll || sh_table[i] == c.table_req)) begin
                    owed_q.push_back(mk_res(i, 0, 0, 1, sh_table[i], sh_page[i], 1'b0));
                    sh_dirty[i] = 0;
                    n++;
                end
            if (n == 0) owed_q.push_back(mk_res(0, 0, 0, 0, '0, '0, 1'b1));
            else owed_q[$].last = 1'b1;
        end
    endtask

    // driver: one command per transfer, random idle bursts
    int push_idle = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                predict_directory('{op: i_op, table_req: i_table_req, page: i_page});
                void'(cmd_q.pop_front());
            end
            if (push_idle > 0) begin
                push_idle <= push_idle - 1;
                push <= 1'b0;
            end else if ((push && !full) && !calm && $urandom_range(0, 9) == 0) begin
                push_idle <= $urandom_range(1, 16) - 1;
                push <= 1'b0;
            end else begin
                // head of queue after any transfer this edge
                if (cmd_q.size() != 0) begin
                    push <= 1'b1;
                    i_op <= cmd_q[0].op;
                    i_table_req <= cmd_q[0].table_req;
                    i_page <= cmd_q[0].page;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each popped result with the oldest owed one
    int pop_idle = 0;
    int quiet = 0;
    always @(posedge i_clk) begin
        lpbd_pkg::t_res w;
        if (i_rst_n) begin
            if ((pop && !empty) || (push && !full)) quiet <= 0;
            else quiet <= quiet + 1;
            if (pop && !empty) begin
                if (owed_q.size() == 0) begin
                    report("unexpected result", 32'(o_frame), 32'd0);
                end else begin
                    w = owed_q.pop_front();
                    if (o_frame !== w.frame)
                        report("frame", 32'(o_frame), 32'(w.frame));
                    if (o_hit !== w.hit)
                        report("hit", 32'(o_hit), 32'(w.hit));
                    if (o_fetch_needed !== w.fetch_needed)
                        report("fetch_needed", 32'(o_fetch_needed), 32'(w.fetch_needed));
                    if (o_writeback_valid !== w.writeback_valid)
                        report("writeback_valid", 32'(o_writeback_valid),
                               32'(w.writeback_valid));
                    if (o_writeback_table !== w.writeback_table)
                        report("writeback_table", 32'(o_writeback_table),
                               32'(w.writeback_table));
                    if (o_writeback_page !== w.writeback_page)
                        report("writeback_page", 32'(o_writeback_page),
                               32'(w.writeback_page));
                    if (o_last !== w.last)
                        report("last", 32'(o_last), 32'(w.last));
                end
            end
            if (pop_idle > 0) begin
                pop_idle <= pop_idle - 1;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop_idle <= $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic lpbd_pkg::t_cmd access(input logic [1:0] op, input logic [3:0] t,
                                              input logic [19:0] p);
        lpbd_pkg::t_cmd c;
        c.op = op; c.table_req = t; c.page = p;
        return c;
    endfunction

    initial begin
        lpbd_pkg::t_cmd c;
        int k;
        for (int i = 0; i < NFRAMES; i++) begin
            sh_valid[i] = 0; sh_table[i] = '0; sh_page[i] = '0; sh_dirty[i] = 0;
            sh_rank[i] = i;
        end
        for (int i = 0; i < 8; i++) hot_pages[i] = 20'($urandom_range(0, 20'hFFFFF));

        // directed: empty flushes, field extremes, hits, dirty eviction, big flush
        cmd_q.push_back(access(lpbd_pkg::OpFlushAll, 4'h0, '0));
        cmd_q.push_back(access(lpbd_pkg::OpFlushOne, 4'hF, 20'hFFFFF));
        cmd_q.push_back(access(lpbd_pkg::OpRead, 4'h0, 20'h00000));
        cmd_q.push_back(access(lpbd_pkg::OpRead, 4'h0, 20'h00000));
        cmd_q.push_back(access(lpbd_pkg::OpWrite, 4'hF, 20'hFFFFF));
        cmd_q.push_back(access(lpbd_pkg::OpWrite, 4'hF, 20'hFFFFF));
        cmd_q.push_back(access(lpbd_pkg::OpFlushOne, 4'hF, '0));
        for (int i = 0; i < 16; i++)
            cmd_q.push_back(access(lpbd_pkg::OpWrite, i[3:0], 20'(20'h5A5A0 + i)));
        cmd_q.push_back(access(lpbd_pkg::OpRead, 4'h3, 20'hAAAAA));
        cmd_q.push_back(access(lpbd_pkg::OpFlushAll, 4'h0, '0));

        // random: mostly accesses to a small working set so hits and evictions mix
        for (int i = 0; i < 185; i++) begin
            k = $urandom_range(0, 99);
            c.table_req = 4'($urandom_range(0, 3));
            if (k < 8) begin
                c.op = lpbd_pkg::OpFlushOne; c.table_req = 4'($urandom_range(0, 15));
            end else if (k < 12) begin
                c.op = lpbd_pkg::OpFlushAll;
            end else begin
                c.op = $urandom_range(0, 1) ? lpbd_pkg::OpWrite : lpbd_pkg::OpRead;
            end
            if ($urandom_range(0, 3) == 0) begin
                c.page = 20'($urandom_range(0, 20'hFFFFF));
                c.table_req = 4'($urandom_range(0, 15));
            end else begin
                c.page = hot_pages[$urandom_range(0, 7)] ^ 20'($urandom_range(0, 3));
            end
            cmd_q.push_back(c);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() > 20) @(posedge i_clk);
        calm = 1;
        while (cmd_q.size() != 0 || owed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && empty === 1'b1) begin
            $display("TB_OK");
        end else begin
            if (empty !== 1'b1) n_errors++;
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ lru_page_buffer_directory.f @@
+incdir+rtl
rtl/lpbd_pkg.sv
rtl/lpbd_fifo.sv
rtl/lpbd_engine.sv
rtl/lru_page_buffer_directory.sv
tb/tb_lru_page_buffer_directory.sv
